// ===== sv/lsfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsfp_pkg
// shared types and constants of the line sensor frame processor
// ----------------------------------------------------------------------------
package lsfp_pkg;

	typedef enum logic [1:0] {
		FUNC_SAMPLE  = 2'd0,
		FUNC_RESTART = 2'd1,
		FUNC_CLR_LINE = 2'd2,
		FUNC_CLR_MARK = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_WHITE = 3'd0,
		REG_BLACK = 3'd1,
		REG_VALID = 3'd2,
		REG_POL   = 3'd3,
		REG_THR   = 3'd4,
		REG_MMIN  = 3'd5,
		REG_MGAP  = 3'd6
	} reg_idx_t;

	localparam int unsigned ADC_BITS   = 12;
	localparam int unsigned LEVEL_MAX  = 100;
	localparam int unsigned RAW_CLAMP  = 255;
	localparam int unsigned MIN_WEIGHT = 15;
	localparam int unsigned CROSS_MIN  = 5;
	localparam logic [7:0] EDGE_BITS   = 8'h81;
	localparam logic [7:0] CENTER_BITS = 8'h7E;
	localparam logic [7:0] RIGHT_BIT   = 8'h80;

	localparam logic [1:0] MARK_LEFT  = 2'd0;
	localparam logic [1:0] MARK_RIGHT = 2'd1;
	localparam logic [1:0] MARK_END   = 2'd2;
	localparam logic [1:0] MARK_CROSS = 2'd3;

	// serial divider widths: numerator up to 6850*100 fits 20 bits magnitude
	localparam int unsigned DIV_W = 20;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	function automatic logic signed [12:0] sensor_offset(input logic [2:0] idx);
		logic signed [12:0] r;
		r = '0;
		case (idx)
			3'd1: r = -13'sd3750;
			3'd2: r = -13'sd2350;
			3'd3: r = -13'sd750;
			3'd4: r = 13'sd750;
			3'd5: r = 13'sd2350;
			3'd6: r = 13'sd3750;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lsfp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsfp_in_if / lsfp_out_if
// valid/ready channels of the line sensor frame processor
// ----------------------------------------------------------------------------
interface lsfp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [lsfp_pkg::ADC_BITS-1:0] adc_sample;
	modport source (output valid, func, adc_sample, input ready);
	modport sink (input valid, func, adc_sample, output ready);
endinterface

interface lsfp_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         slot;
	logic [6:0]         normalized;
	logic [7:0]         line_mask;
	logic               frame_end;
	logic signed [12:0] position;
	logic               found;
	logic signed [13:0] delta;
	logic               mark_valid;
	logic [1:0]         mark_type;
	modport source (output valid, slot, normalized, line_mask, frame_end, position, found,
		delta, mark_valid, mark_type, input ready);
	modport sink (input valid, slot, normalized, line_mask, frame_end, position, found,
		delta, mark_valid, mark_type, output ready);
endinterface
`default_nettype wire

// ===== sv/lsfp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsfp_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsfp_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire lsfp_pkg::div_req_t      req,
	output logic                         done,
	output logic [lsfp_pkg::DIV_W-1:0]   quot
);
	localparam int unsigned W = lsfp_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {rem_q, num_q[W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				num_q <= {num_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				num_q <= {num_q[W-2:0], 1'b0};
			end
		end
	end

	// quotient bits shift into num_q as the dividend shifts out
	assign quot = num_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != '0)
		else $error("divider count underflow");
endmodule
`default_nettype wire

// ===== sv/lsfp_marker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsfp_marker
// per-frame marker tracker on the end sensors
// ----------------------------------------------------------------------------
module lsfp_marker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       clear,
	input  wire logic       step,
	input  wire logic [7:0] bits,
	input  wire logic [7:0] min_ticks,
	input  wire logic [7:0] gap_ticks,
	output logic            mark_valid,
	output logic [1:0]      mark_type
);
	logic        tracking_q;
	logic [31:0] tick_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [7:0]  accum_q;
	logic [31:0] tick_nx;
	logic [7:0]  acc_nx;
	logic [3:0]  ones;
	logic        edge_hit;
	logic        confirm;
	logic [1:0]  kind;

	assign tick_nx  = tick_q + 32'd1;
	assign acc_nx   = accum_q | bits;
	assign edge_hit = (bits & lsfp_pkg::EDGE_BITS) != '0;
	assign confirm  = tracking_q && !edge_hit && ((tick_nx - start_q) >= {24'd0, min_ticks});

	always_comb begin
		ones = '0;
		for (int i = 0; i < 8; i++) begin
			ones = ones + 4'((acc_nx & lsfp_pkg::CENTER_BITS) >> i & 8'd1);
		end
	end

	always_comb begin
		if ((acc_nx & lsfp_pkg::EDGE_BITS) == lsfp_pkg::EDGE_BITS)
			kind = (ones >= 4'(lsfp_pkg::CROSS_MIN)) ? lsfp_pkg::MARK_CROSS : lsfp_pkg::MARK_END;
		else if ((acc_nx & lsfp_pkg::RIGHT_BIT) != '0)
			kind = lsfp_pkg::MARK_RIGHT;
		else
			kind = lsfp_pkg::MARK_LEFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			tick_q     <= '0;
			start_q    <= '0;
			end_q      <= '0;
			accum_q    <= '0;
			mark_valid <= 1'b0;
			mark_type  <= '0;
		end else if (clear) begin
			tracking_q <= 1'b0;
			tick_q     <= '0;
			start_q    <= '0;
			end_q      <= '0;
			accum_q    <= '0;
			mark_valid <= 1'b0;
			mark_type  <= '0;
		end else if (step) begin
			tick_q     <= tick_nx;
			mark_valid <= confirm;
			mark_type  <= confirm ? kind : '0;
			if (!tracking_q) begin
				if (edge_hit && (tick_nx - end_q) >= {24'd0, gap_ticks}) begin
					tracking_q <= 1'b1;
					start_q    <= tick_nx;
					accum_q    <= bits;
				end
			end else begin
				accum_q <= acc_nx;
				if (!edge_hit) begin
					tracking_q <= 1'b0;
					end_q      <= tick_nx;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $rose(mark_valid) |-> $past(step))
		else $error("marker without frame step");
	assert property (@(posedge clk) disable iff (!arst_n) !mark_valid |-> mark_type == '0)
		else $error("marker type without valid");
	assert property (@(posedge clk) disable iff (!arst_n) mark_valid |-> !tracking_q)
		else $error("marker confirmed while tracking");
endmodule
`default_nettype wire

// ===== sv/line_sensor_frame_processor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_sensor_frame_processor_core
// round-robin IR sensor normalization, line position and marker detection
// ----------------------------------------------------------------------------
// One item at a time. A command item goes straight to the output state. A
// sample is normalized on the shared bit-serial divider. Slot 7 then runs a
// six-sensor weight accumulation and, unless the weight sum is zero, a second
// serial division for the position before the frame end item is output. The
// result sits in an output register; the next item is taken once it has been
// handed off.
module line_sensor_frame_processor_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lsfp_in_if.sink          in_ch,
	lsfp_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam int unsigned W = lsfp_pkg::DIV_W;
	localparam int unsigned ADC_BITS = lsfp_pkg::ADC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM_WAIT, ST_NORM_DONE, ST_ACC, ST_POS_START, ST_POS_WAIT,
		ST_POS_DONE, ST_OUT
	} state_t;

	logic [63:0] white_q, black_q;
	logic [7:0]  vmask_q;
	logic        pol_q;
	logic [6:0]  thr_q;
	logic [7:0]  mmin_q, mgap_q;

	state_t state_q;
	logic [2:0]  scan_q;
	logic [7:0]  bits_q;
	logic [6:0]  level_q [8];
	logic signed [12:0] held_q, prev_q;
	logic        seen_q;
	logic signed [13:0] delta_q;

	logic [2:0]  cur_slot_q;
	logic        use_q;
	logic [2:0]  acc_i_q;
	logic signed [20:0] sum_pw_q;
	logic [9:0]  sum_w_q;
	logic        neg_q;
	logic        mstep_q;

	logic        div_start;
	lsfp_pkg::div_req_t div_req;
	logic        div_done;
	logic [W-1:0] div_quot;
	logic        mk_valid;
	logic [1:0]  mk_type;

	// sample front end
	logic [ADC_BITS-1:0] raw_in;
	logic [7:0] raw_c, wb, bb, lo, hi;
	logic [6:0] norm_c;
	logic       white_c;
	logic [6:0] acc_n, acc_w0;
	logic [6:0] acc_w;
	logic signed [19:0] prod;
	logic [W-1:0] pw_mag;
	logic signed [12:0] pos_c;

	assign raw_in = in_ch.adc_sample;
	assign raw_c  = (raw_in > ADC_BITS'(lsfp_pkg::RAW_CLAMP)) ? 8'hFF : raw_in[7:0];
	assign wb = white_q[8*scan_q +: 8];
	assign bb = black_q[8*scan_q +: 8];
	assign lo = (wb < bb) ? wb : bb;
	assign hi = (wb < bb) ? bb : wb;

	assign norm_c  = (div_quot > W'(lsfp_pkg::LEVEL_MAX)) ? 7'(lsfp_pkg::LEVEL_MAX) :
		div_quot[6:0];
	assign white_c = use_q && (pol_q ? ({1'b0, norm_c} >= {1'b0, thr_q} && 1'b1) :
		(norm_c < thr_q));

	assign acc_n  = level_q[acc_i_q];
	assign acc_w0 = pol_q ? acc_n : 7'(7'(lsfp_pkg::LEVEL_MAX) - acc_n);
	assign acc_w  = (!vmask_q[acc_i_q] || acc_w0 < 7'(lsfp_pkg::MIN_WEIGHT)) ? '0 : acc_w0;
	assign prod   = 20'(lsfp_pkg::sensor_offset(acc_i_q)) * $signed({13'd0, acc_w});
	assign pw_mag = sum_pw_q[20] ? W'(-sum_pw_q) : W'(sum_pw_q);
	assign pos_c  = neg_q ? 13'(-$signed({1'b0, div_quot[12:0]})) :
		$signed(div_quot[12:0]);

	lsfp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .req(div_req),
		.done(div_done), .quot(div_quot)
	);

	lsfp_marker u_mark (
		.clk(clk), .arst_n(arst_n),
		.clear(state_q == ST_IDLE && in_ch.valid && in_ch.ready &&
			in_ch.func == lsfp_pkg::FUNC_CLR_MARK),
		.step(mstep_q), .bits(bits_q), .min_ticks(mmin_q), .gap_ticks(mgap_q),
		.mark_valid(mk_valid), .mark_type(mk_type)
	);

	always_comb begin
		div_start = 1'b0;
		div_req   = '{num: '0, den: '0};
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready &&
			in_ch.func == lsfp_pkg::FUNC_SAMPLE) begin
			div_start   = 1'b1;
			div_req.num = (raw_c > lo) ? W'(({8'd0, raw_c - lo}) * 16'd100) : '0;
			div_req.den = (hi > lo) ? W'(hi - lo) : W'(1);
		end else if (state_q == ST_POS_START) begin
			div_start   = 1'b1;
			div_req.num = pw_mag;
			div_req.den = W'(sum_w_q);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_ch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '0; black_q <= '0; vmask_q <= '0; pol_q <= 1'b1;
			thr_q <= 7'd50; mmin_q <= 8'd8; mgap_q <= 8'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsfp_pkg::REG_WHITE: white_q <= cfg_data;
				lsfp_pkg::REG_BLACK: black_q <= cfg_data;
				lsfp_pkg::REG_VALID: vmask_q <= cfg_data[7:0];
				lsfp_pkg::REG_POL:   pol_q   <= cfg_data[0];
				lsfp_pkg::REG_THR:   thr_q   <= cfg_data[6:0];
				lsfp_pkg::REG_MMIN:  mmin_q  <= cfg_data[7:0];
				lsfp_pkg::REG_MGAP:  mgap_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; scan_q <= '0; bits_q <= '0;
			for (int i = 0; i < 8; i++) level_q[i] <= '0;
			held_q <= '0; prev_q <= '0; seen_q <= 1'b0; delta_q <= '0;
			cur_slot_q <= '0; use_q <= 1'b0; acc_i_q <= '0;
			sum_pw_q <= '0; sum_w_q <= '0; neg_q <= 1'b0; mstep_q <= 1'b0;
			out_ch.valid <= 1'b0; out_ch.slot <= '0; out_ch.normalized <= '0;
			out_ch.frame_end <= 1'b0;
		end else begin
			mstep_q <= (state_q == ST_ACC) && (acc_i_q == 3'd6);
			if (state_q == ST_OUT) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						out_ch.frame_end  <= 1'b0;
						out_ch.normalized <= '0;
						unique case (in_ch.func)
							lsfp_pkg::FUNC_SAMPLE: begin
								cur_slot_q <= scan_q;
								use_q <= vmask_q[scan_q] && (hi > lo);
								state_q <= ST_NORM_WAIT;
							end
							lsfp_pkg::FUNC_RESTART: begin
								scan_q <= '0; out_ch.slot <= '0; state_q <= ST_OUT;
							end
							lsfp_pkg::FUNC_CLR_LINE: begin
								held_q <= '0; prev_q <= '0; seen_q <= 1'b0;
								delta_q <= '0; out_ch.slot <= scan_q; state_q <= ST_OUT;
							end
							default: begin
								out_ch.slot <= scan_q; state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_NORM_WAIT: if (div_done) state_q <= ST_NORM_DONE;
				ST_NORM_DONE: begin
					level_q[cur_slot_q] <= use_q ? norm_c : '0;
					out_ch.normalized   <= use_q ? norm_c : '0;
					bits_q[cur_slot_q]  <= white_c;
					out_ch.slot <= cur_slot_q;
					scan_q <= cur_slot_q + 3'd1;
					if (cur_slot_q == 3'd7) begin
						out_ch.frame_end <= 1'b1;
						acc_i_q <= 3'd1; sum_pw_q <= '0; sum_w_q <= '0;
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_ACC: begin
					sum_pw_q <= sum_pw_q + prod;
					sum_w_q  <= sum_w_q + {3'd0, acc_w};
					if (acc_i_q == 3'd6) begin
						state_q <= ST_POS_START;
					end
					acc_i_q <= acc_i_q + 3'd1;
				end
				ST_POS_START: begin
					neg_q <= sum_pw_q[20];
					state_q <= (sum_w_q == '0) ? ST_POS_DONE : ST_POS_WAIT;
				end
				ST_POS_WAIT: if (div_done) state_q <= ST_POS_DONE;
				ST_POS_DONE: begin
					if (sum_w_q != '0) begin
						held_q <= pos_c;
						delta_q <= 14'(pos_c) - 14'(prev_q);
						prev_q <= pos_c;
						seen_q <= 1'b1;
					end else begin
						delta_q <= 14'(held_q) - 14'(prev_q);
						prev_q <= held_q;
						seen_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.line_mask  = bits_q;
	assign out_ch.position   = held_q;
	assign out_ch.found      = seen_q;
	assign out_ch.delta      = delta_q;
	// marker outcome belongs only to the frame end item
	assign out_ch.mark_valid = mk_valid && out_ch.frame_end;
	assign out_ch.mark_type  = out_ch.frame_end ? mk_type : '0;

	assert property (@(posedge clk) disable iff (!arst_n) in_ch.ready |-> !out_ch.valid)
		else $error("input taken with result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.mark_valid |-> out_ch.frame_end)
		else $error("marker outside frame end");
endmodule
`default_nettype wire
